FILE: hdl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and the CRC-8 step function of the frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned VERDICT_W = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MY_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER = 2'd2;

    // Verdict codes.
    localparam logic [VERDICT_W-1:0] VERDICT_OK     = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_SHORT  = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_MARKER = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_CRC    = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_ADDR   = 3'd4;

    localparam logic [LEN_W-1:0]  ABS_MIN_LENGTH = 16'd6;
    localparam logic [BYTE_W-1:0] CRC_POLY       = 8'h8C;

    localparam logic [BYTE_W-1:0] MY_ADDRESS_RST = 8'd0;
    localparam logic [LEN_W-1:0]  MIN_LENGTH_RST = 16'd6;
    localparam logic [BYTE_W-1:0] END_MARKER_RST = 8'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] my_address;
        logic [LEN_W-1:0]  min_length;
        logic [BYTE_W-1:0] end_marker;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data_byte;
        logic              frame_start;
    } item_t;

    typedef struct packed {
        logic                 valid;
        logic [VERDICT_W-1:0] verdict;
        logic [BYTE_W-1:0]    sender_address;
        logic [LEN_W-1:0]     frame_length;
    } result_t;

    // One byte of the reflected Dallas/Maxim CRC-8, initial value zero.
    function automatic logic [BYTE_W-1:0] crc8_step(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] b
    );
        logic [BYTE_W-1:0] v;
        v = crc ^ b;
        for (int i = 0; i < BYTE_W; i++) begin
            if (v[0])
            begin
                v = (v >> 1) ^ CRC_POLY;
            end
            else
            begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

endpackage

FILE: hdl/sfr_in_stage.sv
// ----------------------------------------------------------------------------
// sfr_in_stage
// Input register: captures one byte per transfer and holds it until the
// parser can take it.
// ----------------------------------------------------------------------------
module sfr_in_stage (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [sfr_pkg::BYTE_W-1:0] data_byte,
    input  logic                     frame_start,
    input  logic                     advance,
    output sfr_pkg::item_t           item
);
    import sfr_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              start_reg;
    logic              take;

    // The held byte blocks the port only while the result side cannot move.
    assign in_stall   = valid_reg & ~advance;
    assign take       = in_valid & ~in_stall;
    assign valid_next = take | (valid_reg & ~advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg  <= data_byte;
            start_reg <= frame_start;
        end
    end

    assign item.valid       = valid_reg;
    assign item.data_byte   = data_reg;
    assign item.frame_start = start_reg;

endmodule

FILE: hdl/sfr_parse.sv
// ----------------------------------------------------------------------------
// sfr_parse
// Frame state machine: tracks the byte position, runs the CRC, checks the
// length and produces the verdict at the last byte or at a rejected length.
// ----------------------------------------------------------------------------
module sfr_parse (
    input  logic             clk,
    input  logic             rst_n,
    input  sfr_pkg::cfg_t    cfg,
    input  sfr_pkg::item_t   item,
    input  logic             advance,
    output sfr_pkg::result_t res
);
    import sfr_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY
    } phase_t;

    phase_t            phase_reg, phase_next, phase_eff;
    logic [LEN_W-1:0]  byte_index_reg, byte_index_next, idx_eff;
    logic [LEN_W-1:0]  length_reg, length_next, len_eff;
    logic [BYTE_W-1:0] crc_reg, crc_next, crc_eff;
    logic              crc_ok_reg, crc_ok_next, crc_ok_eff;
    logic [BYTE_W-1:0] sender_reg, sender_next, sender_eff;
    logic              match_reg, match_next, match_eff;
    logic [LEN_W:0]    idx_plus2;
    logic [LEN_W-1:0]  len_new;
    logic              step;
    logic [BYTE_W-1:0] b;

    assign step = item.valid & advance;
    assign b    = item.data_byte;

    always_comb
    begin
        if (item.frame_start)
        begin
            phase_eff  = PH_HEADER;
            idx_eff    = '0;
            len_eff    = '0;
            crc_eff    = '0;
            crc_ok_eff = 1'b0;
            sender_eff = '0;
            match_eff  = 1'b0;
        end
        else
        begin
            phase_eff  = phase_reg;
            idx_eff    = byte_index_reg;
            len_eff    = length_reg;
            crc_eff    = crc_reg;
            crc_ok_eff = crc_ok_reg;
            sender_eff = sender_reg;
            match_eff  = match_reg;
        end

        phase_next      = phase_eff;
        byte_index_next = idx_eff;
        length_next     = len_eff;
        crc_next        = crc_eff;
        crc_ok_next     = crc_ok_eff;
        sender_next     = sender_eff;
        match_next      = match_eff;
        idx_plus2       = {1'b0, idx_eff} + {{(LEN_W-1){1'b0}}, 2'd2};
        len_new         = {len_eff[LEN_W-1:BYTE_W], b};

        res.valid          = 1'b0;
        res.verdict        = VERDICT_OK;
        res.sender_address = sender_eff;
        res.frame_length   = len_eff;

        unique case (phase_eff)
            PH_HEADER:
            begin
                crc_next        = crc8_step(crc_eff, b);
                byte_index_next = idx_eff + 16'd1;
                if (idx_eff == 16'd0)
                begin
                    match_next = (b == cfg.my_address);
                end
                else if (idx_eff == 16'd1)
                begin
                    sender_next = b;
                end
                else if (idx_eff == 16'd2)
                begin
                    length_next = {b, {BYTE_W{1'b0}}};
                end
                else
                begin
                    length_next      = len_new;
                    res.frame_length = len_new;
                    if (len_new < ABS_MIN_LENGTH || len_new < cfg.min_length)
                    begin
                        res.valid       = 1'b1;
                        res.verdict     = VERDICT_SHORT;
                        phase_next      = PH_IDLE;
                        byte_index_next = idx_eff;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
            end
            PH_BODY:
            begin
                if (idx_plus2 < {1'b0, len_eff})
                begin
                    crc_next        = crc8_step(crc_eff, b);
                    byte_index_next = idx_eff + 16'd1;
                end
                else if (idx_plus2 == {1'b0, len_eff})
                begin
                    crc_ok_next     = (crc_eff == b);
                    byte_index_next = idx_eff + 16'd1;
                end
                else
                begin
                    // Last byte: end marker first, then CRC, then address.
                    res.valid  = 1'b1;
                    phase_next = PH_IDLE;
                    if (b != cfg.end_marker)
                    begin
                        res.verdict = VERDICT_MARKER;
                    end
                    else if (!crc_ok_eff)
                    begin
                        res.verdict = VERDICT_CRC;
                    end
                    else if (!match_eff)
                    begin
                        res.verdict = VERDICT_ADDR;
                    end
                    else
                    begin
                        res.verdict = VERDICT_OK;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        res.valid = res.valid & step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            byte_index_reg <= '0;
            length_reg     <= '0;
            crc_reg        <= '0;
            crc_ok_reg     <= 1'b0;
            sender_reg     <= '0;
            match_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            length_reg     <= length_next;
            crc_reg        <= crc_next;
            crc_ok_reg     <= crc_ok_next;
            sender_reg     <= sender_next;
            match_reg      <= match_next;
        end
    end

endmodule

FILE: hdl/sfr_out_stage.sv
// ----------------------------------------------------------------------------
// sfr_out_stage
// Result register: holds one verdict until the receiving side takes it.
// ----------------------------------------------------------------------------
module sfr_out_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sfr_pkg::result_t              res,
    output logic                          advance,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sfr_pkg::VERDICT_W-1:0] verdict,
    output logic [sfr_pkg::BYTE_W-1:0]    sender_address,
    output logic [sfr_pkg::LEN_W-1:0]     frame_length
);
    import sfr_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [VERDICT_W-1:0] verdict_reg;
    logic [BYTE_W-1:0]    sender_reg;
    logic [LEN_W-1:0]     length_reg;

    // The register is free when empty or when its result is taken this cycle.
    assign advance    = ~valid_reg | ~out_stall;
    assign valid_next = res.valid | (valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            verdict_reg <= res.verdict;
            sender_reg  <= res.sender_address;
            length_reg  <= res.frame_length;
        end
    end

    assign out_valid      = valid_reg;
    assign verdict        = verdict_reg;
    assign sender_address = sender_reg;
    assign frame_length   = length_reg;

endmodule

FILE: hdl/serial_frame_receiver_crc8_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_crc8_unit
// Length-prefixed frame receiver with a running Dallas/Maxim CRC-8 check.
// ----------------------------------------------------------------------------
// The unit takes one frame byte per clock cycle unless input is held back. Each
// byte is captured in an input register, processed by the frame state machine
// from there and, when it ends a frame, its verdict is loaded into the result
// register, which presents it until the output side takes it. The one-cycle rate
// is set by the CRC-8 byte update, which runs as a single step of combinational
// logic; input is held back only while a verdict waits in the result register
// and the output is stalled. Configuration writes take effect on the next
// clock edge and are meant to be made between frames.
module serial_frame_receiver_crc8_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [sfr_pkg::BYTE_W-1:0]        data_byte,
    input  logic                              frame_start,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sfr_pkg::VERDICT_W-1:0]     verdict,
    output logic [sfr_pkg::BYTE_W-1:0]        sender_address,
    output logic [sfr_pkg::LEN_W-1:0]         frame_length,
    input  logic                              cfg_write_en,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sfr_pkg::*;

    cfg_t    cfg_reg;
    item_t   item;
    result_t res;
    logic    advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.my_address <= MY_ADDRESS_RST;
            cfg_reg.min_length <= MIN_LENGTH_RST;
            cfg_reg.end_marker <= END_MARKER_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_MY_ADDRESS: cfg_reg.my_address <= cfg_data[BYTE_W-1:0];
                CFG_MIN_LENGTH: cfg_reg.min_length <= cfg_data[LEN_W-1:0];
                CFG_END_MARKER: cfg_reg.end_marker <= cfg_data[BYTE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    sfr_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .frame_start (frame_start),
        .advance     (advance),
        .item        (item)
    );

    sfr_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .item    (item),
        .advance (advance),
        .res     (res)
    );

    sfr_out_stage u_out_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .res            (res),
        .advance        (advance),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .verdict        (verdict),
        .sender_address (sender_address),
        .frame_length   (frame_length)
    );

    // Input is held back only by a verdict that the output side refuses.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

    a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (verdict <= VERDICT_ADDR))
        else $error("verdict code out of range");

    a_short_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && verdict == VERDICT_SHORT) |->
            (frame_length < ABS_MIN_LENGTH || frame_length < cfg_reg.min_length))
        else $error("short-frame verdict with an acceptable length");

    a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !res.valid)
        else $error("new verdict produced while the result register is blocked");

endmodule

FILE: dv/sfr_frame_checker.sv
// ----------------------------------------------------------------------------
// Frame receiver checker
// Watches the byte, result and register ports of the frame receiver, tracks
// each frame byte by byte with its own CRC-8 and header decoding, and compares
// every verdict transfer with the oldest predicted verdict.
// ----------------------------------------------------------------------------
package sfr_tb_pkg;

    // Reflected CRC-8 with polynomial 0x8C, one data bit per step.
    function automatic logic [7:0] maxim_crc_byte(
        input logic [7:0] crc_in,
        input logic [7:0] data
    );
        logic [7:0] crc;
        logic       feedback;
        crc = crc_in;
        for (int i = 0; i < 8; i++)
        begin
            feedback = crc[0] ^ data[i];
            crc = crc >> 1;
            if (feedback)
            begin
                crc = crc ^ sfr_pkg::CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

module sfr_frame_checker
    import sfr_pkg::*;
    import sfr_tb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic                 frame_start,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [VERDICT_W-1:0] verdict,
    input  logic [BYTE_W-1:0]    sender_address,
    input  logic [LEN_W-1:0]     frame_length,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                   mismatch_count,
    output int                   pending_results,
    output int                   verdicts_checked,
    output logic [4:0]           verdicts_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {RX_IDLE, RX_HEADER, RX_BODY} rx_phase_e;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [BYTE_W-1:0]    sender;
        logic [LEN_W-1:0]     length;
    } frame_verdict_t;

    frame_verdict_t verdict_q[$];

    logic [BYTE_W-1:0] my_address_cfg;
    logic [LEN_W-1:0]  min_length_cfg;
    logic [BYTE_W-1:0] end_marker_cfg;

    rx_phase_e         rx_phase;
    logic [LEN_W-1:0]  byte_idx;
    logic [LEN_W-1:0]  len_field;
    logic [BYTE_W-1:0] crc_acc;
    logic [BYTE_W-1:0] sender_id;
    logic              crc_match;
    logic              dest_match;

    task automatic close_frame(input logic [VERDICT_W-1:0] code);
        verdict_q.push_back({code, sender_id, len_field});
        rx_phase = RX_IDLE;
    endtask

    task automatic track_byte(input logic [BYTE_W-1:0] b, input logic fs);
        if (fs)
        begin
            rx_phase   = RX_HEADER;
            byte_idx   = '0;
            len_field  = '0;
            crc_acc    = '0;
            crc_match  = 1'b0;
            sender_id  = '0;
            dest_match = 1'b0;
        end
        case (rx_phase)
            RX_HEADER:
            begin
                crc_acc = maxim_crc_byte(crc_acc, b);
                case (byte_idx)
                    16'd0: dest_match = (b == my_address_cfg);
                    16'd1: sender_id = b;
                    16'd2: len_field = {b, 8'h00};
                    default:
                    begin
                        // The length is judged as soon as its low byte arrives.
                        len_field[7:0] = b;
                        if (len_field < ABS_MIN_LENGTH || len_field < min_length_cfg)
                        begin
                            close_frame(VERDICT_SHORT);
                        end
                        else
                        begin
                            rx_phase = RX_BODY;
                        end
                    end
                endcase
                byte_idx = byte_idx + 1'b1;
            end
            RX_BODY:
            begin
                if (int'(byte_idx) + 2 < int'(len_field))
                begin
                    crc_acc = maxim_crc_byte(crc_acc, b);
                end
                else if (int'(byte_idx) + 2 == int'(len_field))
                begin
                    crc_match = (crc_acc == b);
                end
                else if (b != end_marker_cfg)
                begin
                    close_frame(VERDICT_MARKER);
                end
                else if (!crc_match)
                begin
                    close_frame(VERDICT_CRC);
                end
                else if (!dest_match)
                begin
                    close_frame(VERDICT_ADDR);
                end
                else
                begin
                    close_frame(VERDICT_OK);
                end
                byte_idx = byte_idx + 1'b1;
            end
            default:
            begin
                // Bytes outside a frame are dropped by the receiver.
            end
        endcase
    endtask

    task automatic check_verdict();
        frame_verdict_t exp_v;
        if (verdict_q.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
            begin
                $display("%0t: verdict transfer with none pending: verdict %0d sender %02h length %0d",
                         $realtime, verdict, sender_address, frame_length);
            end
        end
        else
        begin
            exp_v = verdict_q.pop_front();
            verdicts_checked++;
            if (exp_v.verdict <= VERDICT_ADDR)
            begin
                verdicts_seen[exp_v.verdict] = 1'b1;
            end
            if (verdict !== exp_v.verdict || sender_address !== exp_v.sender ||
                frame_length !== exp_v.length)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("%0t: verdict mismatch: expected %0d/%02h/%0d, got %0d/%02h/%0d",
                             $realtime, exp_v.verdict, exp_v.sender, exp_v.length,
                             verdict, sender_address, frame_length);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            verdict_q.delete();
            my_address_cfg   = MY_ADDRESS_RST;
            min_length_cfg   = MIN_LENGTH_RST;
            end_marker_cfg   = END_MARKER_RST;
            rx_phase         = RX_IDLE;
            byte_idx         = '0;
            len_field        = '0;
            crc_acc          = '0;
            crc_match        = 1'b0;
            sender_id        = '0;
            dest_match       = 1'b0;
            mismatch_count   = 0;
            pending_results  = 0;
            verdicts_checked = 0;
            verdicts_seen    = '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_MY_ADDRESS: my_address_cfg = cfg_data[BYTE_W-1:0];
                    CFG_MIN_LENGTH: min_length_cfg = cfg_data[LEN_W-1:0];
                    CFG_END_MARKER: end_marker_cfg = cfg_data[BYTE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
            begin
                track_byte(data_byte, frame_start);
            end
            if (out_valid && !out_stall)
            begin
                check_verdict();
            end
            pending_results = verdict_q.size();
        end
    end

endmodule

FILE: dv/tb_serial_frame_receiver_crc8_unit.sv
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Sends directed and random frames (good, corrupted, short, abandoned and
// stray bytes) under several register settings with bursty input and a
// stalling result side; the checker module predicts and compares verdicts.
// ----------------------------------------------------------------------------
module tb_serial_frame_receiver_crc8_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sfr_pkg::*;
    import sfr_tb_pkg::*;

    localparam int RANDOM_BYTES    = 1550;
    localparam int RANDOM_SETTINGS = 6;
    localparam int IDLE_LIMIT      = 3000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 12;
    localparam int HOLD_OFF_CYCLES = 250;

    typedef enum int {FRAME_GOOD, FRAME_BAD_MARKER, FRAME_BAD_CRC, FRAME_CUT} frame_fault_e;
    typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_LIGHT} stall_pattern_e;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic [BYTE_W-1:0]     data_byte    = '0;
    logic                  frame_start  = 1'b0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [VERDICT_W-1:0]  verdict;
    logic [BYTE_W-1:0]     sender_address;
    logic [LEN_W-1:0]      frame_length;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    int         mismatch_count;
    int         pending_results;
    int         verdicts_checked;
    logic [4:0] verdicts_seen;

    logic [BYTE_W-1:0] cur_my     = MY_ADDRESS_RST;
    logic [LEN_W-1:0]  cur_min    = MIN_LENGTH_RST;
    logic [BYTE_W-1:0] cur_marker = END_MARKER_RST;
    int                bytes_sent     = 0;
    int                burst_left     = 0;
    int                settings_used  = 1;
    logic              hold_off_req   = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    serial_frame_receiver_crc8_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .frame_start    (frame_start),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .verdict        (verdict),
        .sender_address (sender_address),
        .frame_length   (frame_length),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    sfr_frame_checker frame_chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .frame_start      (frame_start),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .verdict          (verdict),
        .sender_address   (sender_address),
        .frame_length     (frame_length),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .pending_results  (pending_results),
        .verdicts_checked (verdicts_checked),
        .verdicts_seen    (verdicts_seen)
    );

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic fs);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        frame_start <= fs;
        // The stall input settles between edges, so look at it mid-cycle.
        @(negedge clk);
        while (in_stall)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (pending_results != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(
        input logic [BYTE_W-1:0] my_addr,
        input logic [LEN_W-1:0]  min_len,
        input logic [BYTE_W-1:0] marker
    );
        in_valid <= 1'b0;
        wait_drained();
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_MY_ADDRESS;
        cfg_data     <= {8'h00, my_addr};
        @(posedge clk);
        cfg_index    <= CFG_MIN_LENGTH;
        cfg_data     <= min_len;
        @(posedge clk);
        cfg_index    <= CFG_END_MARKER;
        cfg_data     <= {8'h00, marker};
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cur_my     = my_addr;
        cur_min    = min_len;
        cur_marker = marker;
        settings_used++;
    endtask

    task automatic send_frame(
        input logic [BYTE_W-1:0] dst,
        input logic [BYTE_W-1:0] src,
        input logic [LEN_W-1:0]  len,
        input frame_fault_e      fault
    );
        logic [BYTE_W-1:0] crc;
        logic [BYTE_W-1:0] b;
        int                total;
        int                sent;
        int                k;
        // A rejected length ends the frame after the header.
        total = (len < ABS_MIN_LENGTH || len < cur_min) ? 4 : int'(len);
        sent  = total;
        if (fault == FRAME_CUT)
        begin
            sent = $urandom_range(1, (total - 1 < 30) ? total - 1 : 30);
        end
        crc = '0;
        for (k = 0; k < sent; k++)
        begin
            if (k == 0)
                b = dst;
            else if (k == 1)
                b = src;
            else if (k == 2)
                b = len[15:8];
            else if (k == 3)
                b = len[7:0];
            else if (k < total - 2)
                b = 8'($urandom);
            else if (k == total - 2)
                b = (fault == FRAME_BAD_CRC) ? crc ^ (8'h01 << $urandom_range(0, 7)) : crc;
            else
                b = (fault == FRAME_BAD_MARKER) ? cur_marker ^ 8'($urandom_range(1, 255))
                                                : cur_marker;
            if (k < total - 2)
            begin
                crc = maxim_crc_byte(crc, b);
            end
            push_byte(b, k == 0);
        end
    endtask

    task automatic send_random_frame();
        logic [BYTE_W-1:0] dst;
        logic [LEN_W-1:0]  len;
        frame_fault_e      fault;
        int                pick;
        int                size_pick;
        int                n;
        pick      = $urandom_range(0, 99);
        size_pick = $urandom_range(0, 99);
        dst = ($urandom_range(0, 3) != 0) ? cur_my : 8'($urandom);
        if (pick < 6)
        begin
            // Stray bytes with no frame start.
            n = $urandom_range(1, 3);
            repeat (n) push_byte(8'($urandom), 1'b0);
        end
        else
        begin
            if (pick < 62)
                fault = FRAME_GOOD;
            else if (pick < 72)
                fault = FRAME_BAD_MARKER;
            else if (pick < 82)
                fault = FRAME_BAD_CRC;
            else
                fault = FRAME_CUT;
            if (size_pick < 5)
            begin
                len = 16'($urandom_range(0, 5));
            end
            else if (size_pick < 8)
            begin
                len   = 16'($urandom);
                fault = FRAME_CUT;
            end
            else if (size_pick < 93)
            begin
                len = 16'($urandom_range(6, 24));
            end
            else
            begin
                len = 16'($urandom_range(200, 300));
            end
            send_frame(dst, 8'($urandom), len, fault);
        end
    endtask

    // Result side: changing stall patterns plus one long hold-off on request.
    initial
    begin
        stall_pattern_e pattern;
        int             span;
        int             cyc;
        int             hold_left;
        logic           hold_done;
        pattern   = STALL_NONE;
        span      = 0;
        cyc       = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (span == 0)
            begin
                pattern = stall_pattern_e'($urandom_range(0, 3));
                span    = $urandom_range(20, 160);
            end
            span--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                case (pattern)
                    STALL_NONE:     out_stall <= 1'b0;
                    STALL_COIN:     out_stall <= 1'($urandom_range(0, 1));
                    STALL_PERIODIC: out_stall <= (cyc % 7) < 3;
                    default:        out_stall <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Watchdog: ends the run when no transfer happens on either side for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int s;
        int first;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames at the reset settings.
        send_frame(8'h00, 8'hFF, 16'd6, FRAME_GOOD);
        send_frame(8'hFF, 8'h00, 16'h0000, FRAME_GOOD);
        push_byte(8'h5A, 1'b0);
        // A frame start that the next frame start abandons.
        push_byte(8'h00, 1'b1);
        send_frame(8'h00, 8'h12, 16'd6, FRAME_BAD_MARKER);
        send_frame(8'h00, 8'h34, 16'd6, FRAME_BAD_CRC);

        for (s = 0; s < RANDOM_SETTINGS; s++)
        begin
            case (s)
                0:                   apply_settings(8'hFF, 16'd2, 8'hFF);
                1:                   apply_settings(8'h5A, 16'd12, 8'h00);
                RANDOM_SETTINGS - 1: apply_settings(8'($urandom), 16'hFFFF, 8'($urandom));
                default:             apply_settings(8'($urandom), 16'($urandom_range(6, 20)),
                                                    8'($urandom));
            endcase
            if (s == 0)
            begin
                send_frame(8'h00, 8'h56, 16'd6, FRAME_GOOD);
                // Rejected as too short although the minimum is set below six.
                send_frame(8'hFF, 8'hAB, 16'd5, FRAME_GOOD);
                hold_off_req <= 1'b1;
            end
            first = bytes_sent;
            while (bytes_sent - first < RANDOM_BYTES / RANDOM_SETTINGS)
            begin
                send_random_frame();
            end
            if (s == RANDOM_SETTINGS - 1)
            begin
                // Start of a maximum-length frame, abandoned within its first 30 bytes.
                send_frame(cur_my, 8'($urandom), 16'hFFFF, FRAME_CUT);
            end
        end

        in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes under %0d register settings; %0d verdicts checked.",
                 bytes_sent, settings_used, verdicts_checked);
        $display("Verdict codes seen (bit 0 = accepted, bit 4 = other address): %05b",
                 verdicts_seen);
        if (mismatch_count == 0 && pending_results == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches, %0d verdicts never delivered",
                     mismatch_count, pending_results);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
